/* hw/rtl/pcb_pkg.sv */
`timescale 1ns / 1ps

package pcb_pkg;

  localparam int IdxW      = 6;   // point_index width
  localparam int SegCntW   = 5;   // segment_count register and internal segment number
  localparam int SegOutW   = 4;   // segment_used width
  localparam int SlotW     = 5;   // point_index / 3
  localparam int ChunkW    = 31;  // multiplicand slice per partial product
  localparam int PipeDepth = 11;  // register stages from input to result

  // idx / 3 as (idx * 43) >> 7, exact for idx below 128
  localparam int Recip3      = 43;
  localparam int Recip3Shift = 7;

  typedef enum logic {
    KindWrite = 1'b0,
    KindEval  = 1'b1
  } kind_e;

  // control point banks: index mod 3
  typedef enum logic [1:0] {
    BankEnd  = 2'd0,
    BankMid1 = 2'd1,
    BankMid2 = 2'd2
  } bank_e;

  typedef struct packed {
    bank_e            bank;
    logic [SlotW-1:0] slot;
  } slot_t;

  typedef struct packed {
    logic prod;
    logic sum;
  } step_en_t;

  typedef struct packed {
    logic     coef;
    step_en_t s1;
    step_en_t s2;
    step_en_t s3;
    logic     result;
  } axis_en_t;

  function automatic slot_t index_to_slot(logic [IdxW-1:0] idx);
    logic [IdxW+Recip3Shift-1:0] prod;
    logic [SlotW-1:0]            q;
    logic [IdxW-1:0]             rem;
    slot_t                       r;
    prod = (IdxW+Recip3Shift)'(idx) * (IdxW+Recip3Shift)'(Recip3);
    q    = SlotW'(prod >> Recip3Shift);
    rem  = idx - (IdxW'(q) + (IdxW'(q) << 1));
    r.slot = q;
    case (rem[1:0])
      2'd0:    r.bank = BankEnd;
      2'd1:    r.bank = BankMid1;
      2'd2:    r.bank = BankMid2;
      default: r.bank = BankEnd;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/pcb_point_store.sv */
`timescale 1ns / 1ps

module pcb_point_store #(
  parameter int MAX_SEGMENTS = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  pcb_pkg::slot_t                      wr_slot_i,
  input  logic signed [COORD_BITS-1:0]        wr_x_i,
  input  logic signed [COORD_BITS-1:0]        wr_y_i,
  input  logic                                rd_en_i,
  input  logic        [pcb_pkg::SegCntW-1:0]  rd_seg_i,
  output logic signed [COORD_BITS-1:0]        rd_x_o [4],
  output logic signed [COORD_BITS-1:0]        rd_y_o [4]
);

  localparam int EntryW   = 2 * COORD_BITS;
  localparam int DepthEnd = MAX_SEGMENTS + 1;
  localparam int DepthMid = MAX_SEGMENTS;
  localparam int AEndW    = $clog2(DepthEnd);
  localparam int AMidW    = (DepthMid > 1) ? $clog2(DepthMid) : 1;

  // end points 3k live in end_mem[k], inner points 3k+1 / 3k+2 in the mid banks
  logic [EntryW-1:0] end_mem  [DepthEnd];
  logic [EntryW-1:0] mid1_mem [DepthMid];
  logic [EntryW-1:0] mid2_mem [DepthMid];
  logic [EntryW-1:0] rd_q     [4];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      case (wr_slot_i.bank)
        pcb_pkg::BankEnd:  end_mem[AEndW'(wr_slot_i.slot)]  <= {wr_x_i, wr_y_i};
        pcb_pkg::BankMid1: mid1_mem[AMidW'(wr_slot_i.slot)] <= {wr_x_i, wr_y_i};
        pcb_pkg::BankMid2: mid2_mem[AMidW'(wr_slot_i.slot)] <= {wr_x_i, wr_y_i};
        default: ;
      endcase
    end
    if (rd_en_i) begin
      rd_q[0] <= end_mem[AEndW'(rd_seg_i)];
      rd_q[1] <= mid1_mem[AMidW'(rd_seg_i)];
      rd_q[2] <= mid2_mem[AMidW'(rd_seg_i)];
      rd_q[3] <= end_mem[AEndW'(rd_seg_i) + AEndW'(1)];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_x_o[i] = rd_q[i][EntryW-1:COORD_BITS];
      rd_y_o[i] = rd_q[i][COORD_BITS-1:0];
    end
  end

endmodule

/* hw/rtl/pcb_horner_step.sv */
`timescale 1ns / 1ps

// y = x * u + k over two stages: sliced partial products, then their sum with k
module pcb_horner_step #(
  parameter int X_W   = 20,
  parameter int U_W   = 17,
  parameter int OUT_W = 38
) (
  input  logic                    clk_i,
  input  pcb_pkg::step_en_t       en_i,
  input  logic signed [X_W-1:0]   x_i,
  input  logic        [U_W-1:0]   u_i,
  input  logic signed [OUT_W-1:0] k_i,
  output logic signed [OUT_W-1:0] y_o
);

  localparam int ChunkW    = pcb_pkg::ChunkW;
  localparam int NumChunks = (X_W + ChunkW - 1) / ChunkW;
  localparam int ProdW     = ChunkW + U_W + 2;

  logic signed [ChunkW:0]    op     [NumChunks];
  logic signed [ProdW-1:0]   prod_q [NumChunks];
  logic signed [U_W:0]       u_s;
  logic signed [OUT_W-1:0]   k_q;
  logic signed [OUT_W-1:0]   y_d;
  logic signed [OUT_W-1:0]   y_q;

  assign u_s = {1'b0, u_i};

  // lower slices are unsigned, the top slice carries the sign
  for (genvar i = 0; i < NumChunks; i++) begin : g_chunk
    if (i < NumChunks - 1) begin : g_low
      assign op[i] = {1'b0, x_i[i*ChunkW +: ChunkW]};
    end else begin : g_top
      assign op[i] = (ChunkW+1)'($signed(x_i[X_W-1:i*ChunkW]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      for (int i = 0; i < NumChunks; i++) begin
        prod_q[i] <= op[i] * u_s;
      end
      k_q <= k_i;
    end
  end

  always_comb begin
    y_d = k_q;
    for (int i = 0; i < NumChunks; i++) begin
      y_d = y_d + (OUT_W'(prod_q[i]) <<< (i * ChunkW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

/* hw/rtl/pcb_axis_eval.sv */
`timescale 1ns / 1ps

// One coordinate: power-basis coefficients, three Horner steps, round and saturate.
module pcb_axis_eval #(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  pcb_pkg::axis_en_t            en_i,
  input  logic signed [COORD_BITS-1:0] p_i [4],
  input  logic        [T_FRAC_BITS:0]  u_i,
  output logic signed [COORD_BITS-1:0] result_o
);

  localparam int UW  = T_FRAC_BITS + 1;
  localparam int CW  = COORD_BITS + 4;
  localparam int H1W = CW + UW + 1;
  localparam int H2W = H1W + UW + 1;
  localparam int H3W = H2W + UW + 1;
  localparam int RW  = H3W - 3 * T_FRAC_BITS;

  localparam logic [COORD_BITS-1:0] MaxC = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MinC = ~MaxC;

  logic signed [CW-1:0] e0, e1, e2, e3, d10, d21, s2, a_d, b_d, c_d;

  always_comb begin
    e0  = CW'(p_i[0]);
    e1  = CW'(p_i[1]);
    e2  = CW'(p_i[2]);
    e3  = CW'(p_i[3]);
    d10 = e1 - e0;
    d21 = e2 - e1;
    s2  = e2 - (e1 <<< 1) + e0;
    c_d = (d10 <<< 1) + d10;
    b_d = (s2 <<< 1) + s2;
    a_d = e3 - e0 - ((d21 <<< 1) + d21);
  end

  logic signed [CW-1:0]         a4_q, b4_q, c4_q, c5_q, c6_q;
  logic signed [COORD_BITS-1:0] p04_q, p05_q, p06_q, p07_q, p08_q;
  logic        [UW-1:0]         u4_q, u5_q, u6_q, u7_q, u8_q;

  always_ff @(posedge clk_i) begin
    if (en_i.coef) begin
      a4_q  <= a_d;
      b4_q  <= b_d;
      c4_q  <= c_d;
      p04_q <= p_i[0];
      u4_q  <= u_i;
    end
    if (en_i.s1.prod) begin
      c5_q  <= c4_q;
      p05_q <= p04_q;
      u5_q  <= u4_q;
    end
    if (en_i.s1.sum) begin
      c6_q  <= c5_q;
      p06_q <= p05_q;
      u6_q  <= u5_q;
    end
    if (en_i.s2.prod) begin
      p07_q <= p06_q;
      u7_q  <= u6_q;
    end
    if (en_i.s2.sum) begin
      p08_q <= p07_q;
      u8_q  <= u7_q;
    end
  end

  logic signed [H1W-1:0] k1, h1;
  logic signed [H2W-1:0] k2, h2;
  logic signed [H3W-1:0] k3, h3;

  assign k1 = H1W'(b4_q) <<< T_FRAC_BITS;
  assign k2 = H2W'(c6_q) <<< (2 * T_FRAC_BITS);
  // p0 term plus one half for round to nearest
  assign k3 = (H3W'(p08_q) <<< (3 * T_FRAC_BITS)) + (H3W'(1) <<< (3 * T_FRAC_BITS - 1));

  pcb_horner_step #(.X_W(CW), .U_W(UW), .OUT_W(H1W)) u_step1 (
    .clk_i (clk_i),
    .en_i  (en_i.s1),
    .x_i   (a4_q),
    .u_i   (u4_q),
    .k_i   (k1),
    .y_o   (h1)
  );

  pcb_horner_step #(.X_W(H1W), .U_W(UW), .OUT_W(H2W)) u_step2 (
    .clk_i (clk_i),
    .en_i  (en_i.s2),
    .x_i   (h1),
    .u_i   (u6_q),
    .k_i   (k2),
    .y_o   (h2)
  );

  pcb_horner_step #(.X_W(H2W), .U_W(UW), .OUT_W(H3W)) u_step3 (
    .clk_i (clk_i),
    .en_i  (en_i.s3),
    .x_i   (h2),
    .u_i   (u8_q),
    .k_i   (k3),
    .y_o   (h3)
  );

  logic [RW-1:0]           whole;
  logic [RW-COORD_BITS:0]  upper;
  logic [COORD_BITS-1:0]   res_d;
  logic signed [COORD_BITS-1:0] res_q;

  always_comb begin
    whole = h3[H3W-1:3*T_FRAC_BITS];
    upper = whole[RW-1:COORD_BITS-1];
    if ((&upper) || !(|upper)) begin
      res_d = whole[COORD_BITS-1:0];
    end else if (whole[RW-1]) begin
      res_d = MinC;
    end else begin
      res_d = MaxC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.result) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

/* hw/rtl/piecewise_cubic_bezier_eval.sv */
`timescale 1ns / 1ps

// Piecewise cubic Bezier evaluator. Takes one transaction per clock while in_stall_o
// is low: a control point write or an evaluation at global t (Q1.T_FRAC_BITS). The
// pipeline has 11 register stages; while out_stall_i is low one result can follow
// another every cycle. Writes pass the stage 1 and stage 2 registers and land in the
// point store when stage 3 loads, always ahead of any later evaluation. Points are
// banked by index mod 3 so all four points of a segment come out of one registered
// read; the end-point bank has two read ports. The three Horner multiplications are
// sliced into partial products of at most 32 bits, each taking a product stage and a
// sum stage. Point slots are not cleared at reset: a slot must be written before a
// segment that uses it is evaluated. cfg_ready_o is always high; write segment_count
// only while the block is idle.
module piecewise_cubic_bezier_eval #(
  parameter int MAX_SEGMENTS = 16,
  parameter int COORD_BITS   = 16,
  parameter int T_FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic        [pcb_pkg::SegCntW-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic        [pcb_pkg::IdxW-1:0]    point_index_i,
  input  logic signed [COORD_BITS-1:0]       point_x_i,
  input  logic signed [COORD_BITS-1:0]       point_y_i,
  input  logic        [T_FRAC_BITS:0]        t_param_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [COORD_BITS-1:0]       curve_x_o,
  output logic signed [COORD_BITS-1:0]       curve_y_o,
  output logic        [pcb_pkg::SegOutW-1:0] segment_used_o
);

  localparam int UW         = T_FRAC_BITS + 1;
  localparam int ProdW      = T_FRAC_BITS + pcb_pkg::SegCntW;
  localparam int StoreDepth = 3 * MAX_SEGMENTS + 1;
  localparam int LastStage  = pcb_pkg::PipeDepth;
  localparam int SegW       = pcb_pkg::SegCntW;
  localparam logic [UW-1:0] OneT = UW'(1) << T_FRAC_BITS;

  // configuration
  logic [SegW-1:0] cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= SegW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // pipeline control: a stage loads unless it and every stage after it are full and the output stalls
  logic [LastStage:1] valid_q;
  logic [LastStage:1] ld;

  for (genvar k = 1; k <= LastStage; k++) begin : g_ld
    assign ld[k] = !out_stall_i || !(&valid_q[LastStage:k]);
  end

  assign in_stall_o = !ld[1];

  pcb_pkg::kind_e kind2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ld[1]) valid_q[1] <= in_valid_i;
      if (ld[2]) valid_q[2] <= valid_q[1];
      // write transactions end at the store
      if (ld[3]) valid_q[3] <= valid_q[2] && (kind2_q == pcb_pkg::KindEval);
      for (int k = 4; k <= LastStage; k++) begin
        if (ld[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 1: input register
  pcb_pkg::kind_e               kind1_q;
  logic [pcb_pkg::IdxW-1:0]     idx1_q;
  logic signed [COORD_BITS-1:0] x1_q, y1_q;
  logic [UW-1:0]                t1_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      kind1_q <= pcb_pkg::kind_e'(kind_i);
      idx1_q  <= point_index_i;
      x1_q    <= point_x_i;
      y1_q    <= point_y_i;
      t1_q    <= t_param_i;
    end
  end

  // segment select and local parameter
  logic [SegW-1:0]   n_eff, seg_raw, seg1;
  logic [UW-1:0]     t_sat, u1;
  logic [ProdW-1:0]  scaled;
  logic [SegW+1:0]   chain_end;
  logic              wr_ok1;
  pcb_pkg::slot_t    slot1;

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = SegW'(1);
    end else if (int'(cfg_q) > MAX_SEGMENTS) begin
      n_eff = SegW'(MAX_SEGMENTS);
    end else begin
      n_eff = cfg_q;
    end
    t_sat   = (t1_q > OneT) ? OneT : t1_q;
    scaled  = ProdW'(t_sat) * ProdW'(n_eff);
    seg_raw = scaled[ProdW-1:T_FRAC_BITS];
    // t = 1.0 lands past the last segment: clamp, local u becomes 1.0
    seg1    = (seg_raw >= n_eff) ? (n_eff - SegW'(1)) : seg_raw;
    u1      = UW'(scaled - (ProdW'(seg1) << T_FRAC_BITS));
    chain_end = (SegW+2)'(n_eff) + ((SegW+2)'(n_eff) << 1);
    wr_ok1  = (kind1_q == pcb_pkg::KindWrite) &&
              ((SegW+2)'(idx1_q) <= chain_end) &&
              (int'(idx1_q) < StoreDepth);
    slot1   = pcb_pkg::index_to_slot(idx1_q);
  end

  // stage 2
  logic                         wr2_q;
  pcb_pkg::slot_t               slot2_q;
  logic signed [COORD_BITS-1:0] x2_q, y2_q;
  logic [SegW-1:0]              seg2_q;
  logic [UW-1:0]                u2_q, u3_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      kind2_q <= kind1_q;
      wr2_q   <= wr_ok1;
      slot2_q <= slot1;
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      seg2_q  <= seg1;
      u2_q    <= u1;
    end
    if (ld[3]) begin
      u3_q <= u2_q;
    end
  end

  // stage 3: point store read data
  logic signed [COORD_BITS-1:0] px [4];
  logic signed [COORD_BITS-1:0] py [4];
  logic                         store_wr, store_rd;

  assign store_wr = ld[3] && valid_q[2] && wr2_q;
  assign store_rd = ld[3] && valid_q[2] && (kind2_q == pcb_pkg::KindEval);

  pcb_point_store #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (store_wr),
    .wr_slot_i (slot2_q),
    .wr_x_i    (x2_q),
    .wr_y_i    (y2_q),
    .rd_en_i   (store_rd),
    .rd_seg_i  (seg2_q),
    .rd_x_o    (px),
    .rd_y_o    (py)
  );

  // segment number rides along to the output
  logic [SegW-1:0] seg_q [3:LastStage];

  always_ff @(posedge clk_i) begin
    if (ld[3]) seg_q[3] <= seg2_q;
    for (int k = 4; k <= LastStage; k++) begin
      if (ld[k]) seg_q[k] <= seg_q[k-1];
    end
  end

  // stages 4 to 11: arithmetic per axis
  pcb_pkg::axis_en_t axis_en;

  assign axis_en.coef     = ld[4];
  assign axis_en.s1.prod  = ld[5];
  assign axis_en.s1.sum   = ld[6];
  assign axis_en.s2.prod  = ld[7];
  assign axis_en.s2.sum   = ld[8];
  assign axis_en.s3.prod  = ld[9];
  assign axis_en.s3.sum   = ld[10];
  assign axis_en.result   = ld[11];

  pcb_axis_eval #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_axis_x (
    .clk_i    (clk_i),
    .en_i     (axis_en),
    .p_i      (px),
    .u_i      (u3_q),
    .result_o (curve_x_o)
  );

  pcb_axis_eval #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_axis_y (
    .clk_i    (clk_i),
    .en_i     (axis_en),
    .p_i      (py),
    .u_i      (u3_q),
    .result_o (curve_y_o)
  );

  assign out_valid_o    = valid_q[LastStage];
  assign segment_used_o = seg_q[LastStage][pcb_pkg::SegOutW-1:0];

endmodule

/* hw/rtl/pcb_checker.sv */
`timescale 1ns / 1ps

module pcb_checker #(
  parameter int MAX_SEGMENTS = 16,
  parameter int COORD_BITS   = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic        [pcb_pkg::SegCntW-1:0] cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               kind_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [COORD_BITS-1:0]       curve_x_o,
  input logic signed [COORD_BITS-1:0]       curve_y_o,
  input logic        [pcb_pkg::SegOutW-1:0] segment_used_o
);

  localparam int SegW  = pcb_pkg::SegCntW;
  localparam int CntW  = $clog2(pcb_pkg::PipeDepth + 1) + 1;

  logic [SegW-1:0] cfg_shadow_q, n_eff;
  logic [CntW-1:0] pending_q;
  logic            eval_in, res_out;

  assign eval_in = in_valid_i && !in_stall_o && (kind_i == pcb_pkg::KindEval);
  assign res_out = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_shadow_q <= SegW'(1);
      pending_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cfg_shadow_q <= cfg_data_i;
      pending_q <= pending_q + CntW'(eval_in) - CntW'(res_out);
    end
  end

  always_comb begin
    if (cfg_shadow_q == '0) begin
      n_eff = SegW'(1);
    end else if (int'(cfg_shadow_q) > MAX_SEGMENTS) begin
      n_eff = SegW'(MAX_SEGMENTS);
    end else begin
      n_eff = cfg_shadow_q;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(curve_x_o) &&
                                   $stable(curve_y_o) && $stable(segment_used_o))
    else $error("stalled result changed");

  // the pipeline only backs up when the output side stalls
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  // every result belongs to an accepted evaluation
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out |-> pending_q != '0)
    else $error("result without evaluation");

  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pending_q) <= pcb_pkg::PipeDepth)
    else $error("more evaluations in flight than stages");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (int'(n_eff) <= (1 << pcb_pkg::SegOutW)) |->
      SegW'(segment_used_o) < n_eff)
    else $error("segment outside chain");

endmodule

bind piecewise_cubic_bezier_eval pcb_checker #(
  .MAX_SEGMENTS (MAX_SEGMENTS),
  .COORD_BITS   (COORD_BITS)
) u_pcb_checker (.*);
